// File: hdl/hals2d_pkg.sv
// ----------------------------------------------------------------------------
// hals2d_pkg: shared types and constants for the 2D Halton point generator
// Control word layout, microcode program ROM and base clamping.
// ----------------------------------------------------------------------------
package hals2d_pkg;

   localparam int NUM_LANES  = 2;   // lane 0 = x, lane 1 = y
   localparam int BASE_W     = 5;
   localparam int BASE_MIN   = 2;
   localparam int BASE_MAX   = 16;
   localparam int DIV_UNROLL = 8;   // quotient bits produced per divide cycle
   localparam int PC_W       = 3;

   typedef logic [PC_W-1:0] pc_type;
   typedef logic [2:0]      op_type;
   typedef logic [2:0]      cond_type;

   // datapath operations
   localparam op_type OP_NOP       = 3'd0;
   localparam op_type OP_LOAD      = 3'd1;
   localparam op_type OP_MARK      = 3'd2;
   localparam op_type OP_DIV       = 3'd3;
   localparam op_type OP_DIGIT     = 3'd4;
   localparam op_type OP_FRAC_INIT = 3'd5;
   localparam op_type OP_FRAC      = 3'd6;
   localparam op_type OP_OUT       = 3'd7;

   // jump conditions (jump taken when true, else fall through)
   localparam cond_type COND_NEVER     = 3'd0;
   localparam cond_type COND_ALWAYS    = 3'd1;
   localparam cond_type COND_NO_REQ    = 3'd2;
   localparam cond_type COND_ALL_ZERO  = 3'd3;
   localparam cond_type COND_DIV_MORE  = 3'd4;
   localparam cond_type COND_FRAC_MORE = 3'd5;
   localparam cond_type COND_OUT_BUSY  = 3'd6;

   // program steps
   localparam pc_type STEP_IDLE      = 3'd0;
   localparam pc_type STEP_MARK      = 3'd1;
   localparam pc_type STEP_DIV       = 3'd2;
   localparam pc_type STEP_DIGIT     = 3'd3;
   localparam pc_type STEP_FRAC_INIT = 3'd4;
   localparam pc_type STEP_FRAC      = 3'd5;
   localparam pc_type STEP_WAIT      = 3'd6;
   localparam pc_type STEP_OUT       = 3'd7;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type cw;
      case (pc)
         STEP_IDLE:      cw = '{OP_LOAD,      COND_NO_REQ,    STEP_IDLE};
         STEP_MARK:      cw = '{OP_MARK,      COND_ALL_ZERO,  STEP_FRAC_INIT};
         STEP_DIV:       cw = '{OP_DIV,       COND_DIV_MORE,  STEP_DIV};
         STEP_DIGIT:     cw = '{OP_DIGIT,     COND_ALWAYS,    STEP_MARK};
         STEP_FRAC_INIT: cw = '{OP_FRAC_INIT, COND_NEVER,     STEP_IDLE};
         STEP_FRAC:      cw = '{OP_FRAC,      COND_FRAC_MORE, STEP_FRAC};
         STEP_WAIT:      cw = '{OP_NOP,       COND_OUT_BUSY,  STEP_WAIT};
         STEP_OUT:       cw = '{OP_OUT,       COND_ALWAYS,    STEP_IDLE};
         default:        cw = '{OP_NOP,       COND_ALWAYS,    STEP_IDLE};
      endcase
      return cw;
   endfunction

   // out-of-range register values map to the nearest legal radix
   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      if (b < BASE_W'(BASE_MIN))
         r = BASE_W'(BASE_MIN);
      else if (b > BASE_W'(BASE_MAX))
         r = BASE_W'(BASE_MAX);
      else
         r = b;
      return r;
   endfunction

endpackage

// File: hdl/hals2d_if.sv
// ----------------------------------------------------------------------------
// hals2d channel interfaces
// Valid/ready channels for sample index requests and Halton point responses.
// ----------------------------------------------------------------------------
interface hals2d_req_if #(parameter int INDEX_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] index;

   modport source (output valid, output index, input ready);
   modport sink   (input valid, input index, output ready);
endinterface

interface hals2d_rsp_if #(parameter int FRAC_BITS = 24);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS-1:0] sample_x;
   logic [FRAC_BITS-1:0] sample_y;

   modport source (output valid, output sample_x, output sample_y, input ready);
   modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

// File: hdl/halton_sample_2d.sv
// ----------------------------------------------------------------------------
// halton_sample_2d: 2D Halton point generator
// Steps: accept a request in the idle step; then, per digit of the index in the
//   smaller base, mark, divide and digit steps; then fraction init, fraction, wait, out.
// A new request is taken only back in the idle step, after the previous point is output;
//   the wait step holds while an earlier point still waits on rsp ready.
// Reset (sync, active high): sequencer to idle, rsp empty, base_x=2, base_y=3.
// ----------------------------------------------------------------------------
module halton_sample_2d #(
   parameter int INDEX_BITS = 16,
   parameter int FRAC_BITS  = 24
) (
   input  logic                clock,
   input  logic                reset,
   hals2d_req_if.sink          req_ch,
   hals2d_rsp_if.source        rsp_ch,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   // Divide datapath is padded to a whole number of 8-bit chunks.
   localparam int CHUNKS = (INDEX_BITS + hals2d_pkg::DIV_UNROLL - 1) / hals2d_pkg::DIV_UNROLL;
   localparam int DIVW   = CHUNKS * hals2d_pkg::DIV_UNROLL;
   // scale = base^digits < 16 * 2^INDEX_BITS
   localparam int SW     = INDEX_BITS + 4;
   localparam int CNT_W  = $clog2(FRAC_BITS);
   localparam int BW     = hals2d_pkg::BASE_W;
   localparam int NL     = hals2d_pkg::NUM_LANES;

   // ---------------------------------------------------------------------
   // Configuration registers (APB, zero wait state)
   // ---------------------------------------------------------------------
   logic [BW-1:0] base_x_ff, base_y_ff;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= BW'(2);
         base_y_ff <= BW'(3);
      end else if (csr_wr) begin
         // register select is address bit 2 (byte offsets 0 and 4)
         if (csr_paddr[2])
            base_y_ff <= csr_pwdata[BW-1:0];
         else
            base_x_ff <= csr_pwdata[BW-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2])
         csr_prdata[BW-1:0] = base_y_ff;
      else
         csr_prdata[BW-1:0] = base_x_ff;
   end

   // ---------------------------------------------------------------------
   // Microcode sequencer
   // ---------------------------------------------------------------------
   hals2d_pkg::pc_type        pc_ff, pc_in;
   hals2d_pkg::ctrl_word_type cw;
   logic                      jump;
   logic                      all_zero;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   assign cw = hals2d_pkg::ucode_rom(pc_ff);

   // Per-lane datapath state (lane 0 = x, lane 1 = y)
   logic [DIVW-1:0]      n_ff[NL],      n_in[NL];       // dividend, becomes quotient
   logic [BW-1:0]        r_ff[NL],      r_in[NL];       // running remainder
   logic [BW-1:0]        base_ff[NL],   base_in[NL];    // clamped radix
   logic [SW-1:0]        mir_ff[NL],    mir_in[NL];     // mirrored digits
   logic [SW-1:0]        scale_ff[NL],  scale_in[NL];   // base^digits
   logic [SW-1:0]        rem_ff[NL],    rem_in[NL];     // fraction remainder
   logic [FRAC_BITS-1:0] q_ff[NL],      q_in[NL];       // fraction bits
   logic                 act_ff[NL],    act_in[NL];     // lane still has digits
   logic [FRAC_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;

   assign all_zero = (n_ff[0] == '0) && (n_ff[1] == '0);

   always_comb begin
      case (cw.cond)
         hals2d_pkg::COND_NEVER:     jump = 1'b0;
         hals2d_pkg::COND_ALWAYS:    jump = 1'b1;
         hals2d_pkg::COND_NO_REQ:    jump = ~req_ch.valid;
         hals2d_pkg::COND_ALL_ZERO:  jump = all_zero;
         hals2d_pkg::COND_DIV_MORE:  jump = (cnt_ff != CNT_W'(CHUNKS - 1));
         hals2d_pkg::COND_FRAC_MORE: jump = (cnt_ff != CNT_W'(FRAC_BITS - 1));
         hals2d_pkg::COND_OUT_BUSY:  jump = rsp_valid_ff;
         default:                    jump = 1'b0;
      endcase
      pc_in = jump ? cw.target : pc_ff + 1'b1;
   end

   // request taken only in the idle step; accept loads the lanes
   assign req_ch.ready = (pc_ff == hals2d_pkg::STEP_IDLE);

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   always_comb begin
      logic [BW-1:0]     r_t;
      logic [DIVW-1:0]   n_t;
      logic [SW+BW-1:0]  mprod, sprod;
      logic [SW:0]       rem2;

      r_t   = '0;
      n_t   = '0;
      mprod = '0;
      sprod = '0;
      rem2  = '0;

      cnt_in   = cnt_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;

      for (int l = 0; l < NL; l++) begin
         n_in[l]     = n_ff[l];
         r_in[l]     = r_ff[l];
         base_in[l]  = base_ff[l];
         mir_in[l]   = mir_ff[l];
         scale_in[l] = scale_ff[l];
         rem_in[l]   = rem_ff[l];
         q_in[l]     = q_ff[l];
         act_in[l]   = act_ff[l];
      end

      case (cw.op)
         hals2d_pkg::OP_LOAD: begin
            for (int l = 0; l < NL; l++) begin
               n_in[l]     = DIVW'(req_ch.index);
               mir_in[l]   = '0;
               scale_in[l] = SW'(1);
            end
            base_in[0] = hals2d_pkg::clamp_base(base_x_ff);
            base_in[1] = hals2d_pkg::clamp_base(base_y_ff);
         end
         hals2d_pkg::OP_MARK: begin
            // start of one digit: remember which lanes still have digits
            for (int l = 0; l < NL; l++) begin
               act_in[l] = (n_ff[l] != '0);
               r_in[l]   = '0;
            end
            cnt_in = '0;
         end
         hals2d_pkg::OP_DIV: begin
            // restoring divide by the radix, 8 quotient bits per cycle
            for (int l = 0; l < NL; l++) begin
               r_t = r_ff[l];
               n_t = n_ff[l];
               for (int s = 0; s < hals2d_pkg::DIV_UNROLL; s++) begin
                  r_t = {r_t[BW-2:0], n_t[DIVW-1]};
                  n_t = {n_t[DIVW-2:0], 1'b0};
                  if (r_t >= base_ff[l]) begin
                     r_t    = r_t - base_ff[l];
                     n_t[0] = 1'b1;
                  end
               end
               r_in[l] = r_t;
               n_in[l] = n_t;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         hals2d_pkg::OP_DIGIT: begin
            // append remainder digit; lanes already exhausted hold
            for (int l = 0; l < NL; l++) begin
               mprod = mir_ff[l] * base_ff[l];
               sprod = scale_ff[l] * base_ff[l];
               if (act_ff[l]) begin
                  mir_in[l]   = mprod[SW-1:0] + SW'(r_ff[l]);
                  scale_in[l] = sprod[SW-1:0];
               end
            end
         end
         hals2d_pkg::OP_FRAC_INIT: begin
            for (int l = 0; l < NL; l++) begin
               rem_in[l] = mir_ff[l];
               q_in[l]   = '0;
            end
            cnt_in = '0;
         end
         hals2d_pkg::OP_FRAC: begin
            // long division mirrored/scale, one fraction bit per cycle
            for (int l = 0; l < NL; l++) begin
               rem2 = {rem_ff[l], 1'b0};
               if (rem2 >= {1'b0, scale_ff[l]}) begin
                  rem2      = rem2 - {1'b0, scale_ff[l]};
                  q_in[l]   = {q_ff[l][FRAC_BITS-2:0], 1'b1};
               end else begin
                  q_in[l]   = {q_ff[l][FRAC_BITS-2:0], 1'b0};
               end
               rem_in[l] = rem2[SW-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
         end
         hals2d_pkg::OP_OUT: begin
            out_x_in     = q_ff[0];
            out_y_in     = q_ff[1];
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= hals2d_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      for (int l = 0; l < NL; l++) begin
         n_ff[l]     <= n_in[l];
         r_ff[l]     <= r_in[l];
         base_ff[l]  <= base_in[l];
         mir_ff[l]   <= mir_in[l];
         scale_ff[l] <= scale_in[l];
         rem_ff[l]   <= rem_in[l];
         q_ff[l]     <= q_in[l];
         act_ff[l]   <= act_in[l];
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.sample_x = out_x_ff;
   assign rsp_ch.sample_y = out_y_ff;

endmodule
